// File: sv/spb_pkg.sv
// Shared types, constants and constant tables for the surplus-production step.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package spb_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int BIOMASS_BITS = 40;
    localparam int RATE_W       = FRAC_BITS + 2;
    localparam int SHAPE_W      = FRAC_BITS + 4;
    localparam int KIND_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int POS_W        = $clog2(BIOMASS_BITS);
    localparam int LOG_FRAC     = 24;
    localparam int LOG_W        = POS_W + LOG_FRAC;
    localparam int CNT_W        = $clog2(LOG_FRAC);
    localparam int MANT_FRAC    = 30;
    localparam int MANT_W       = MANT_FRAC + 1;
    localparam int EXP_W        = LOG_FRAC + 5;
    localparam int MUL_W        = 64;
    localparam int CHUNK        = 16;
    localparam int MUL_STEPS    = MUL_W / CHUNK;
    localparam int DIV_W        = 96;
    localparam int FOX_SHIFT    = LOG_FRAC + 32 - FRAC_BITS;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    // capacity / 10^6 = (capacity >> 6) / 15625; the rounded-up reciprocal of
    // 15625 scaled by 2^48 is exact for every 34-bit dividend
    localparam int FLOOR_PRE_SHIFT = 6;
    localparam int FLOOR_SHIFT     = 48;
    localparam logic [MUL_W-1:0] FLOOR_RECIP =
        ((64'd1 << FLOOR_SHIFT) + 64'd15624) / 64'd15625;
    localparam logic [BIOMASS_BITS-1:0] FULL_SCALE = '1;
    localparam logic [MANT_W-1:0] ONE_Q30 = MANT_W'(1) << MANT_FRAC;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY  = 3'd0,
        CFG_GROWTH    = 3'd1,
        CFG_DEPLETION = 3'd2,
        CFG_KIND      = 3'd3,
        CFG_SHAPE     = 3'd4
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOGISTIC = 2'd0,
        KIND_FOX      = 2'd1,
        KIND_PELLA    = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR_OUT,
        S_RELOAD,
        S_EMIT,
        S_FLOOR,
        S_CLAMP,
        S_LG_MUL1,
        S_LG_DIV,
        S_LG_MUL2,
        S_LOG_NORM,
        S_LOG_SQ,
        S_FOX_MUL1,
        S_FOX_MUL2,
        S_FOX_MUL3,
        S_PT_MUL_E,
        S_PT_EXP,
        S_PT_EXP_MUL,
        S_PT_SHIFT,
        S_PT_MUL1,
        S_PT_MUL2,
        S_PT_DIV,
        S_FINISH
    } state_t;

    // bit-by-bit integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt_f(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bit_v;
        x     = v;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= res + bit_v)
            begin
                x   = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // factors 2^(-2^-i) in Q.30, entry i-1 for i = 1..LOG_FRAC
    function automatic logic [LOG_FRAC-1:0][31:0] exp_tab_f();
        logic [LOG_FRAC-1:0][31:0] tab;
        logic [63:0] t;
        t = isqrt_f(64'd1 << 59);
        for (int i = 0; i < LOG_FRAC; i++)
        begin
            tab[i] = t[31:0];
            t = isqrt_f(t << 30);
        end
        return tab;
    endfunction

    localparam logic [LOG_FRAC-1:0][31:0] EXP_TAB = exp_tab_f();

endpackage
`default_nettype wire

// File: sv/spb_mul.sv
// Iterative 64x64 multiplier: one 64x16 partial product per cycle.
// Depends on spb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spb_mul
    import spb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [MUL_W-1:0]     a,
    input  wire logic [MUL_W-1:0]     b,
    output logic                      done,
    output logic [2*MUL_W-1:0]        product
);

    logic [MUL_W-1:0]             a_reg, a_next;
    logic [MUL_W-1:0]             b_reg, b_next;
    logic [2*MUL_W-1:0]           acc_reg, acc_next;
    logic [$clog2(MUL_STEPS)-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [MUL_W+CHUNK-1:0]       part;

    assign part = a_reg * b_reg[MUL_W-1 -: CHUNK];

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // accumulate most significant chunk first
            acc_next = (acc_reg << CHUNK) + (2*MUL_W)'(part);
            b_next   = b_reg << CHUNK;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(MUL_STEPS))'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

// File: sv/spb_div.sv
// Radix-2 restoring divider, 96-bit dividend by 64-bit divisor, one bit per cycle.
// Depends on spb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spb_div
    import spb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_W-1:0]   dividend,
    input  wire logic [MUL_W-1:0]   divisor,
    output logic                    done,
    output logic [DIV_W-1:0]        quotient
);

    logic [DIV_W-1:0]         dvd_reg, dvd_next;
    logic [MUL_W-1:0]         dvs_reg, dvs_next;
    logic [MUL_W-1:0]         rem_reg, rem_next;
    logic [DIV_W-1:0]         q_reg, q_next;
    logic [$clog2(DIV_W)-1:0] cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [MUL_W:0]           trial;
    logic [MUL_W:0]           diff;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[MUL_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[MUL_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == ($clog2(DIV_W))'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

// File: sv/surplus_production_biomass_step.sv
// Surplus-production biomass step: sequencer, datapath registers and channels.
// Depends on spb_pkg, spb_mul and spb_div.
//
// Usage:
//   Input channel (year_valid / year_stall) carries one year's catch_amount and
//   the series_start flag. Output channel (result_valid / result_stall) returns
//   one beat per input beat: the biomass of that year and config_error.
//   The write port (cfg_write_en, cfg_index, cfg_data) sets capacity, growth
//   rate, initial depletion, model kind and Pella-Tomlinson shape; write only
//   while the block is idle.
//   One beat is worked at a time; year_stall stays high until the stored
//   biomass has advanced, or until an error beat is loaded. The result beat
//   is loaded early: it is registered in S_EMIT, before the stock update,
//   once the output register is free; a start reload passes S_RELOAD first.
//   The curve work runs on the shared 64x64 multiplier (48 products for the
//   two log2 evaluations, up to 24 for the power) and the radix-2 divider
//   (one quotient each for logistic and Pella-Tomlinson); a beat whose
//   biomass is at or above capacity skips the curve work.
//   A stalled result holds in the output register; the block finishes the
//   stock update, takes the next beat and waits before its result until the
//   register frees up.
//   Reset restores the configuration defaults and clears the stock biomass.
`timescale 1ns / 1ps
`default_nettype none
module surplus_production_biomass_step
    import spb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    year_valid,
    output logic                         year_stall,
    input  wire logic [BIOMASS_BITS-1:0] catch_amount,
    input  wire logic                    series_start,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output logic [BIOMASS_BITS-1:0]      biomass,
    output logic                         config_error,
    input  wire logic                    cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [BIOMASS_BITS-1:0] cfg_data
);

    // saturate a wide value to full scale
    function automatic logic [BIOMASS_BITS-1:0] sat_f(input logic [2*MUL_W-1:0] v);
        logic [BIOMASS_BITS-1:0] r;
        r = (|(v >> BIOMASS_BITS)) ? FULL_SCALE : v[BIOMASS_BITS-1:0];
        return r;
    endfunction

    state_t                   state_reg, state_next;

    // configuration
    logic [BIOMASS_BITS-1:0]  capacity_reg, capacity_next;
    logic [RATE_W-1:0]        growth_reg, growth_next;
    logic [RATE_W-1:0]        depletion_reg, depletion_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [SHAPE_W-1:0]       shape_reg, shape_next;

    // recurrence state and working registers
    logic [BIOMASS_BITS-1:0]  stock_reg, stock_next;
    logic [BIOMASS_BITS-1:0]  catch_reg, catch_next;
    logic [BIOMASS_BITS-1:0]  b_reg, b_next;
    logic [BIOMASS_BITS-1:0]  bc_reg, bc_next;
    logic [BIOMASS_BITS-1:0]  floor_reg, floor_next;
    logic [BIOMASS_BITS-1:0]  prod_reg, prod_next;
    logic [BIOMASS_BITS-1:0]  x_reg, x_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [MANT_W-1:0]        m_reg, m_next;
    logic [LOG_FRAC-1:0]      frac_reg, frac_next;
    logic [LOG_W-1:0]         lk_reg, lk_next;
    logic                     log_sel_reg, log_sel_next;
    logic [EXP_W-1:0]         e_reg, e_next;
    logic [MANT_W-1:0]        y_reg, y_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    // shared unit requests
    logic                     mul_req_reg, mul_req_next;
    logic                     div_req_reg, div_req_next;
    logic [DIV_W-1:0]         opa_reg, opa_next;
    logic [MUL_W-1:0]         opb_reg, opb_next;

    // output register
    logic                     result_valid_reg, result_valid_next;
    logic [BIOMASS_BITS-1:0]  result_biomass_reg, result_biomass_next;
    logic                     result_err_reg, result_err_next;

    logic                     mul_done;
    logic [2*MUL_W-1:0]       mul_prod;
    logic                     div_done;
    logic [DIV_W-1:0]         div_q;

    logic                     slot_free;
    logic                     cfg_bad;
    logic [SHAPE_W-1:0]       shape_eff;
    logic [BIOMASS_BITS-1:0]  floor_q;
    logic [MANT_W:0]          sq;
    logic [MANT_W-1:0]        m_sq;
    logic [LOG_FRAC-1:0]      frac_sq;
    logic [LOG_W-1:0]         log_val;
    logic [LOG_W-1:0]         d_val;
    logic [2*MUL_W-1:0]       e_full;
    logic [2*MUL_W-1:0]       fox_ln;
    logic [BIOMASS_BITS:0]    next_sum;
    logic [BIOMASS_BITS:0]    next_net;
    logic [BIOMASS_BITS:0]    next_flr;

    spb_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_req_reg),
        .a       (opa_reg[MUL_W-1:0]),
        .b       (opb_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    spb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_req_reg),
        .dividend (opa_reg),
        .divisor  (opb_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign slot_free = !result_valid_reg || !result_stall;
    assign cfg_bad   = (capacity_reg == '0) || (growth_reg == '0);
    assign shape_eff = (shape_reg == '0) ? SHAPE_W'(1) : shape_reg;
    assign floor_q   = mul_prod[FLOOR_SHIFT +: BIOMASS_BITS];

    // one log2 squaring step: Q1.30 square, renormalize on overflow
    assign sq      = mul_prod[2*MANT_FRAC+1:MANT_FRAC];
    assign m_sq    = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
    assign frac_sq = {frac_reg[LOG_FRAC-2:0], sq[MANT_W]};
    assign log_val = {pos_reg, frac_sq};
    assign d_val   = lk_reg - log_val;

    assign e_full  = mul_prod >> FRAC_BITS;
    assign fox_ln  = mul_prod >> FOX_SHIFT;

    assign next_sum = {1'b0, b_reg} + {1'b0, prod_reg};
    assign next_net = (next_sum > {1'b0, catch_reg}) ? next_sum - {1'b0, catch_reg} : '0;
    assign next_flr = (next_net < {1'b0, floor_reg}) ? {1'b0, floor_reg} : next_net;

    // configuration writes
    always_comb
    begin
        capacity_next  = capacity_reg;
        growth_next    = growth_reg;
        depletion_next = depletion_reg;
        kind_next      = kind_reg;
        shape_next     = shape_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_CAPACITY:  capacity_next  = cfg_data;
                CFG_GROWTH:    growth_next    = cfg_data[RATE_W-1:0];
                CFG_DEPLETION: depletion_next = cfg_data[RATE_W-1:0];
                CFG_KIND:      kind_next      = cfg_data[KIND_W-1:0];
                CFG_SHAPE:     shape_next     = cfg_data[SHAPE_W-1:0];
                default:       ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next          = state_reg;
        stock_next          = stock_reg;
        catch_next          = catch_reg;
        b_next              = b_reg;
        bc_next             = bc_reg;
        floor_next          = floor_reg;
        prod_next           = prod_reg;
        x_next              = x_reg;
        pos_next            = pos_reg;
        m_next              = m_reg;
        frac_next           = frac_reg;
        lk_next             = lk_reg;
        log_sel_next        = log_sel_reg;
        e_next              = e_reg;
        y_next              = y_reg;
        cnt_next            = cnt_reg;
        mul_req_next        = 1'b0;
        div_req_next        = 1'b0;
        opa_next            = opa_reg;
        opb_next            = opb_reg;
        result_valid_next   = result_valid_reg && result_stall;
        result_biomass_next = result_biomass_reg;
        result_err_next     = result_err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (year_valid)
                begin
                    catch_next = catch_amount;
                    b_next     = stock_reg;
                    if (cfg_bad)
                    begin
                        state_next = S_ERR_OUT;
                    end
                    else if (series_start)
                    begin
                        // reload: capacity times initial depletion
                        mul_req_next = 1'b1;
                        opa_next     = DIV_W'(capacity_reg);
                        opb_next     = MUL_W'(depletion_reg);
                        state_next   = S_RELOAD;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_ERR_OUT:
            begin
                if (slot_free)
                begin
                    result_valid_next   = 1'b1;
                    result_biomass_next = '0;
                    result_err_next     = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            S_RELOAD:
            begin
                if (mul_done)
                begin
                    stock_next = sat_f(mul_prod >> FRAC_BITS);
                    b_next     = sat_f(mul_prod >> FRAC_BITS);
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    result_valid_next   = 1'b1;
                    result_biomass_next = b_reg;
                    result_err_next     = 1'b0;
                    // floor of the next biomass: capacity / 10^6 by reciprocal
                    mul_req_next        = 1'b1;
                    opa_next            = DIV_W'(capacity_reg >> FLOOR_PRE_SHIFT);
                    opb_next            = FLOOR_RECIP;
                    state_next          = S_FLOOR;
                end
            end

            S_FLOOR:
            begin
                if (mul_done)
                begin
                    floor_next = (floor_q == '0) ? BIOMASS_BITS'(1) : floor_q;
                    state_next = S_CLAMP;
                end
            end

            S_CLAMP:
            begin
                // lift to one LSB; anything at or above capacity produces nothing
                bc_next = (b_reg == '0) ? BIOMASS_BITS'(1) : b_reg;
                if (bc_next >= capacity_reg)
                begin
                    prod_next  = '0;
                    state_next = S_FINISH;
                end
                else if (kind_reg == KIND_FOX || kind_reg == KIND_PELLA)
                begin
                    x_next       = capacity_reg;
                    pos_next     = POS_W'(BIOMASS_BITS - 1);
                    log_sel_next = 1'b0;
                    state_next   = S_LOG_NORM;
                end
                else
                begin
                    mul_req_next = 1'b1;
                    opa_next     = DIV_W'(bc_next);
                    opb_next     = MUL_W'(capacity_reg - bc_next);
                    state_next   = S_LG_MUL1;
                end
            end

            S_LG_MUL1:
            begin
                if (mul_done)
                begin
                    div_req_next = 1'b1;
                    opa_next     = mul_prod[DIV_W-1:0];
                    opb_next     = MUL_W'(capacity_reg);
                    state_next   = S_LG_DIV;
                end
            end

            S_LG_DIV:
            begin
                if (div_done)
                begin
                    mul_req_next = 1'b1;
                    opa_next     = DIV_W'(div_q[MUL_W-1:0]);
                    opb_next     = MUL_W'(growth_reg);
                    state_next   = S_LG_MUL2;
                end
            end

            S_LG_MUL2:
            begin
                if (mul_done)
                begin
                    prod_next  = sat_f(mul_prod >> FRAC_BITS);
                    state_next = S_FINISH;
                end
            end

            S_LOG_NORM:
            begin
                // left-justify: a byte at a time, then single bits
                if (x_reg[BIOMASS_BITS-1])
                begin
                    m_next       = x_reg[BIOMASS_BITS-1 -: MANT_W];
                    frac_next    = '0;
                    cnt_next     = '0;
                    mul_req_next = 1'b1;
                    opa_next     = DIV_W'(x_reg[BIOMASS_BITS-1 -: MANT_W]);
                    opb_next     = MUL_W'(x_reg[BIOMASS_BITS-1 -: MANT_W]);
                    state_next   = S_LOG_SQ;
                end
                else if (x_reg[BIOMASS_BITS-1 -: 8] == '0)
                begin
                    x_next   = x_reg << 8;
                    pos_next = pos_reg - POS_W'(8);
                end
                else
                begin
                    x_next   = x_reg << 1;
                    pos_next = pos_reg - POS_W'(1);
                end
            end

            S_LOG_SQ:
            begin
                if (mul_done)
                begin
                    m_next    = m_sq;
                    frac_next = frac_sq;
                    if (cnt_reg == CNT_W'(LOG_FRAC - 1))
                    begin
                        if (!log_sel_reg)
                        begin
                            lk_next      = log_val;
                            log_sel_next = 1'b1;
                            x_next       = bc_reg;
                            pos_next     = POS_W'(BIOMASS_BITS - 1);
                            state_next   = S_LOG_NORM;
                        end
                        else if (kind_reg == KIND_FOX)
                        begin
                            mul_req_next = 1'b1;
                            opa_next     = DIV_W'(d_val);
                            opb_next     = MUL_W'(LN2_Q32);
                            state_next   = S_FOX_MUL1;
                        end
                        else
                        begin
                            mul_req_next = 1'b1;
                            opa_next     = DIV_W'(d_val);
                            opb_next     = MUL_W'(shape_eff);
                            state_next   = S_PT_MUL_E;
                        end
                    end
                    else
                    begin
                        cnt_next     = cnt_reg + 1'b1;
                        mul_req_next = 1'b1;
                        opa_next     = DIV_W'(m_sq);
                        opb_next     = MUL_W'(m_sq);
                    end
                end
            end

            S_FOX_MUL1:
            begin
                if (mul_done)
                begin
                    // r times ln(k/b)
                    mul_req_next = 1'b1;
                    opa_next     = DIV_W'(growth_reg);
                    opb_next     = fox_ln[MUL_W-1:0];
                    state_next   = S_FOX_MUL2;
                end
            end

            S_FOX_MUL2:
            begin
                if (mul_done)
                begin
                    mul_req_next = 1'b1;
                    opa_next     = DIV_W'(bc_reg);
                    opb_next     = mul_prod[MUL_W-1:0];
                    state_next   = S_FOX_MUL3;
                end
            end

            S_FOX_MUL3:
            begin
                if (mul_done)
                begin
                    prod_next  = sat_f(mul_prod >> (2*FRAC_BITS));
                    state_next = S_FINISH;
                end
            end

            S_PT_MUL_E:
            begin
                if (mul_done)
                begin
                    e_next = e_full[EXP_W-1:0];
                    if ((e_full >> LOG_FRAC) >= (2*MUL_W)'(31))
                    begin
                        y_next     = '0;
                        state_next = S_PT_SHIFT;
                    end
                    else
                    begin
                        y_next     = ONE_Q30;
                        cnt_next   = '0;
                        state_next = S_PT_EXP;
                    end
                end
            end

            S_PT_EXP:
            begin
                // fraction bits of e, most significant first
                if (e_reg[CNT_W'(LOG_FRAC - 1) - cnt_reg])
                begin
                    mul_req_next = 1'b1;
                    opa_next     = DIV_W'(y_reg);
                    opb_next     = MUL_W'(EXP_TAB[cnt_reg]);
                    state_next   = S_PT_EXP_MUL;
                end
                else if (cnt_reg == CNT_W'(LOG_FRAC - 1))
                begin
                    state_next = S_PT_SHIFT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_PT_EXP_MUL:
            begin
                if (mul_done)
                begin
                    y_next = mul_prod[MANT_FRAC +: MANT_W];
                    if (cnt_reg == CNT_W'(LOG_FRAC - 1))
                    begin
                        state_next = S_PT_SHIFT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_PT_EXP;
                    end
                end
            end

            S_PT_SHIFT:
            begin
                // integer part of e; y is already zero when it is 31 or more
                y_next       = y_reg >> e_reg[EXP_W-1:LOG_FRAC];
                mul_req_next = 1'b1;
                opa_next     = DIV_W'(growth_reg);
                opb_next     = MUL_W'(ONE_Q30 - y_next);
                state_next   = S_PT_MUL1;
            end

            S_PT_MUL1:
            begin
                if (mul_done)
                begin
                    mul_req_next = 1'b1;
                    opa_next     = DIV_W'(mul_prod[MUL_W-1:0]);
                    opb_next     = MUL_W'(bc_reg);
                    state_next   = S_PT_MUL2;
                end
            end

            S_PT_MUL2:
            begin
                if (mul_done)
                begin
                    div_req_next = 1'b1;
                    opa_next     = mul_prod[MANT_FRAC +: DIV_W];
                    opb_next     = MUL_W'(shape_eff);
                    state_next   = S_PT_DIV;
                end
            end

            S_PT_DIV:
            begin
                if (div_done)
                begin
                    prod_next  = sat_f((2*MUL_W)'(div_q));
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // advance: b + P - catch, floored, saturated
                stock_next = next_flr[BIOMASS_BITS] ? FULL_SCALE : next_flr[BIOMASS_BITS-1:0];
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            capacity_reg     <= BIOMASS_BITS'(1) << FRAC_BITS;
            growth_reg       <= RATE_W'(1) << (FRAC_BITS - 1);
            depletion_reg    <= RATE_W'(1) << FRAC_BITS;
            kind_reg         <= KIND_LOGISTIC;
            shape_reg        <= SHAPE_W'(1) << FRAC_BITS;
            stock_reg        <= '0;
            mul_req_reg      <= 1'b0;
            div_req_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            capacity_reg     <= capacity_next;
            growth_reg       <= growth_next;
            depletion_reg    <= depletion_next;
            kind_reg         <= kind_next;
            shape_reg        <= shape_next;
            stock_reg        <= stock_next;
            mul_req_reg      <= mul_req_next;
            div_req_reg      <= div_req_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        catch_reg          <= catch_next;
        b_reg              <= b_next;
        bc_reg             <= bc_next;
        floor_reg          <= floor_next;
        prod_reg           <= prod_next;
        x_reg              <= x_next;
        pos_reg            <= pos_next;
        m_reg              <= m_next;
        frac_reg           <= frac_next;
        lk_reg             <= lk_next;
        log_sel_reg        <= log_sel_next;
        e_reg              <= e_next;
        y_reg              <= y_next;
        cnt_reg            <= cnt_next;
        opa_reg            <= opa_next;
        opb_reg            <= opb_next;
        result_biomass_reg <= result_biomass_next;
        result_err_reg     <= result_err_next;
    end

    assign year_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign biomass      = result_biomass_reg;
    assign config_error = result_err_reg;

endmodule
`default_nettype wire

// File: tb/surplus_production_biomass_step_test.sv
// Testbench for surplus_production_biomass_step: random and directed catch series
// over many register settings, checked against an in-bench fixed-point predictor.
// Depends on spb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module surplus_production_biomass_step_test;
    import spb_pkg::*;

    typedef logic [63:0]  u64_t;
    typedef logic [127:0] u128_t;
    typedef logic [BIOMASS_BITS-1:0] mass_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        mass_t biomass;
        logic  config_error;
    } year_out_t;

    // Scoreboard: carries its own copy of the stock recurrence and registers,
    // predicts each accepted year and compares returned beats in order.
    class stock_scoreboard;
        mass_t     cap_k;
        u64_t      rate_r;
        u64_t      depletion;
        logic [1:0] kind;
        u64_t      shape;
        mass_t     stock;
        year_out_t pending[$];
        int        errors;

        function new();
            cap_k     = mass_t'(1) << FRAC_BITS;
            rate_r    = 64'd1 << (FRAC_BITS - 1);
            depletion = 64'd1 << FRAC_BITS;
            kind      = KIND_LOGISTIC;
            shape     = 64'd1 << FRAC_BITS;
            stock     = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, mass_t val);
            case (idx)
                CFG_CAPACITY:  cap_k = val;
                CFG_GROWTH:    rate_r = 64'(val[RATE_W-1:0]);
                CFG_DEPLETION: depletion = 64'(val[RATE_W-1:0]);
                CFG_KIND:      kind = val[KIND_W-1:0];
                CFG_SHAPE:     shape = 64'(val[SHAPE_W-1:0]);
                default: ;
            endcase
        endfunction

        function u64_t mul_shift(u64_t a, u64_t b, int sh);
            u128_t p;
            p = (u128_t'(a) * u128_t'(b)) >> sh;
            return (p[127:64] != 0) ? '1 : p[63:0];
        endfunction

        function u64_t quotient(u128_t n, u64_t d);
            u128_t q;
            q = n / u128_t'(d);
            return (q[127:64] != 0) ? '1 : q[63:0];
        endfunction

        function u64_t int_sqrt(u64_t v);
            u64_t res, bit_v;
            res = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > v)
                bit_v = bit_v >> 2;
            while (bit_v != 0)
            begin
                if (v >= res + bit_v)
                begin
                    v = v - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else
                    res = res >> 1;
                bit_v = bit_v >> 2;
            end
            return res;
        endfunction

        function u64_t log2_fix(u64_t x);
            int   p;
            u64_t m, frac;
            p = 63;
            frac = 0;
            while (p > 0 && x[p] == 1'b0)
                p--;
            m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
            for (int i = 0; i < LOG_FRAC; i++)
            begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd2 << 30))
                begin
                    m = m >> 1;
                    frac[0] = 1'b1;
                end
            end
            return (u64_t'(p) << LOG_FRAC) | frac;
        endfunction

        function u64_t exp2_neg(u64_t e);
            u64_t ip, t, y;
            ip = e >> LOG_FRAC;
            t = int_sqrt(64'd1 << 59);
            y = 64'd1 << 30;
            if (ip >= 31)
                return 0;
            for (int i = 1; i <= LOG_FRAC; i++)
            begin
                if (e[LOG_FRAC - i])
                    y = (y * t) >> 30;
                t = int_sqrt(t << 30);
            end
            return y >> ip;
        endfunction

        function u64_t surplus(u64_t b);
            u64_t k, d, lnq, s, e, y, p;
            u128_t w;
            k = 64'(cap_k);
            if (b < 1)
                b = 1;
            if (b > 2 * k)
                b = 2 * k;
            if (b >= k)
                return 0;
            if (kind == KIND_FOX)
            begin
                d = log2_fix(k) - log2_fix(b);
                lnq = (d * 64'(LN2_Q32)) >> FOX_SHIFT;
                p = mul_shift(b, rate_r * lnq, 2 * FRAC_BITS);
            end
            else if (kind == KIND_PELLA)
            begin
                s = (shape < 1) ? 64'd1 : shape;
                d = log2_fix(k) - log2_fix(b);
                e = (d * s) >> FRAC_BITS;
                y = exp2_neg(e);
                w = (u128_t'(rate_r * ((64'd1 << 30) - y)) * u128_t'(b)) >> 30;
                p = quotient(w, s);
            end
            else
            begin
                w = u128_t'(b) * u128_t'(k - b);
                p = mul_shift(quotient(w, k), rate_r, FRAC_BITS);
            end
            return (p > 64'(FULL_SCALE)) ? 64'(FULL_SCALE) : p;
        endfunction

        // note an accepted year: queue its result; advance the stock if no error
        function void note_year(mass_t catch_v, logic start);
            year_out_t o;
            u64_t b, nxt, floor_v;
            if (cap_k == 0 || rate_r == 0)
            begin
                o.biomass = '0;
                o.config_error = 1'b1;
                pending.push_back(o);
                return;
            end
            if (start)
            begin
                b = mul_shift(64'(cap_k), depletion, FRAC_BITS);
                stock = (b > 64'(FULL_SCALE)) ? FULL_SCALE : b[BIOMASS_BITS-1:0];
            end
            b = 64'(stock);
            o.biomass = stock;
            o.config_error = 1'b0;
            pending.push_back(o);
            nxt = b + surplus(b);
            nxt = (nxt > 64'(catch_v)) ? nxt - 64'(catch_v) : 0;
            floor_v = 64'(cap_k) / 64'd1000000;
            if (floor_v < 1)
                floor_v = 1;
            if (nxt < floor_v)
                nxt = floor_v;
            if (nxt > 64'(FULL_SCALE))
                nxt = 64'(FULL_SCALE);
            stock = nxt[BIOMASS_BITS-1:0];
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(mass_t got_b, logic got_err);
            year_out_t o;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result beat biomass=%0h", got_b));
                return;
            end
            o = pending.pop_front();
            if (got_b !== o.biomass)
                report($sformatf("biomass %0h, predicted %0h", got_b, o.biomass));
            if (got_err !== o.config_error)
                report($sformatf("config_error %b, predicted %b", got_err, o.config_error));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 year_valid;
    logic                 year_stall;
    mass_t                catch_amount;
    logic                 series_start;
    logic                 result_valid;
    logic                 result_stall;
    mass_t                biomass;
    logic                 config_error;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    mass_t                cfg_data;

    stock_scoreboard sb;
    bit quiet;   // set for the tail of the run: no idling on either side

    surplus_production_biomass_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .year_valid   (year_valid),
        .year_stall   (year_stall),
        .catch_amount (catch_amount),
        .series_start (series_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .biomass      (biomass),
        .config_error (config_error),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #10ms;
        $display("** surplus_production_biomass_step: FAILED **");
        $finish;
    end

    // Receiver: stall one time in three for a random stretch, else run free;
    // hold stall low once the run goes quiet.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (quiet)
            result_stall <= 1'b0;
        else if (stall_left == 0)
        begin
            result_stall <= ($urandom_range(0, 2) == 0);
            stall_left   <= $urandom_range(0, 10);
        end
        else
            stall_left <= stall_left - 1;
    end

    // Check every result beat taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(biomass, config_error);
    end

    // Write one register; leave the write enable high for a following write.
    task write_reg(logic [CFG_IDX_W-1:0] idx, mass_t val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Drive one year beat and hold it until taken; then maybe drop valid for a gap.
    task send_year(mass_t c, logic start);
        int gap;
        year_valid   <= 1'b1;
        catch_amount <= c;
        series_start <= start;
        do
            @(posedge clk);
        while (year_stall);
        sb.note_year(c, start);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            year_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lower valid, wait for every predicted beat, then give the block time
    // to finish advancing the stock before anything touches the registers.
    task drain();
        year_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    // Mostly modest catches relative to capacity, with the odd zero,
    // full-width random or full-scale catch mixed in.
    function mass_t pick_catch();
        logic [71:0] scaled;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return mass_t'({$urandom, $urandom});
            2: return FULL_SCALE;
            default:
            begin
                scaled = 72'(sb.cap_k) * 72'($urandom);
                return mass_t'(scaled >> ($urandom_range(34, 37)));
            end
        endcase
    endfunction

    function mass_t pick_capacity();
        case ($urandom_range(0, 5))
            0: return mass_t'(1);
            1: return FULL_SCALE;
            2: return mass_t'({$urandom, $urandom});
            3: return mass_t'($urandom_range(1, 100)) << FRAC_BITS;
            default: return mass_t'($urandom_range(1, 1000000)) << ($urandom_range(8, 20));
        endcase
    endfunction

    // One phase: set all registers while idle, start a series, run random years.
    task run_phase(mass_t k, mass_t r, mass_t dep, mass_t kd, mass_t s, int years,
                   bit pause_mid);
        drain();
        write_reg(CFG_CAPACITY, k);
        write_reg(CFG_GROWTH, r);
        write_reg(CFG_DEPLETION, dep);
        write_reg(CFG_KIND, kd);
        write_reg(CFG_SHAPE, s);
        cfg_write_en <= 1'b0;
        send_year(pick_catch(), 1'b1);
        for (int i = 1; i < years; i++)
        begin
            if (pause_mid && i == years / 2)
            begin
                year_valid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            send_year(pick_catch(), ($urandom_range(0, 40) == 0));
        end
    endtask

    initial
    begin
        sb = new();
        quiet        = 1'b0;
        rst_n        = 1'b0;
        year_valid   = 1'b0;
        catch_amount = '0;
        series_start = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_CAPACITY;
        cfg_data     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: run from the reset stock with no start, then reload,
        // extreme catches.
        send_year('0, 1'b0);
        send_year('0, 1'b0);
        send_year(FULL_SCALE, 1'b0);
        send_year('0, 1'b1);
        send_year(mass_t'(1), 1'b0);
        send_year(FULL_SCALE, 1'b1);
        send_year('0, 1'b0);

        // Zero capacity, then zero growth: error beats, stock untouched.
        drain();
        write_reg(CFG_CAPACITY, '0);
        cfg_write_en <= 1'b0;
        send_year(mass_t'(5), 1'b1);
        send_year('0, 1'b0);
        drain();
        write_reg(CFG_CAPACITY, mass_t'(1000) << FRAC_BITS);
        write_reg(CFG_GROWTH, '0);
        cfg_write_en <= 1'b0;
        send_year('0, 1'b1);
        drain();
        // Unused register index must be ignored; unused model code runs logistic.
        write_reg(CFG_UNUSED, FULL_SCALE);
        write_reg(CFG_GROWTH, mass_t'(65536));
        write_reg(CFG_KIND, mass_t'(3));
        cfg_write_en <= 1'b0;
        send_year('0, 1'b1);
        send_year(mass_t'(1) << 20, 1'b0);
        send_year('0, 1'b0);

        // Extreme settings for each curve.
        run_phase(mass_t'(1) << 26, mass_t'(262143), mass_t'(131072), KIND_LOGISTIC,
                  mass_t'(65536), 60, 1'b1);
        run_phase(FULL_SCALE, mass_t'(1), '0, KIND_FOX, mass_t'(65536), 60, 1'b0);
        run_phase(mass_t'(1), mass_t'(262143), mass_t'(131072), KIND_FOX, '0, 30, 1'b0);
        run_phase(mass_t'(5000) << FRAC_BITS, mass_t'(262143), mass_t'(9000), KIND_PELLA,
                  '0, 60, 1'b0);
        run_phase(FULL_SCALE, mass_t'(262143), mass_t'(131072), KIND_PELLA,
                  mass_t'(1048575), 60, 1'b0);
        run_phase(mass_t'(300) << FRAC_BITS, mass_t'(40000), mass_t'(20000), KIND_PELLA,
                  mass_t'(1), 60, 1'b0);

        // Random settings.
        for (int ph = 0; ph < 11; ph++)
            run_phase(pick_capacity(), mass_t'($urandom_range(1, 262143)),
                      mass_t'($urandom_range(0, 131072)), mass_t'($urandom_range(0, 3)),
                      mass_t'($urandom_range(0, 1048575)), 70, ph == 4);

        // Tail with no idling on either side.
        quiet = 1'b1;
        run_phase(mass_t'(2000) << FRAC_BITS, mass_t'(50000), mass_t'(30000), KIND_FOX,
                  mass_t'(65536), 80, 1'b0);

        year_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** surplus_production_biomass_step: PASSED **");
        else
            $display("** surplus_production_biomass_step: FAILED **");
        $finish;
    end

endmodule
